/* src/bba_pkg.sv */
// Shared types and constants of the buddy block allocator.
// Used by the channel interfaces, the allocator and the testbench; bba_ram does not use it.
package bba_pkg;

   localparam int SIZE_W    = 11;
   localparam int ADDR_W    = 10;
   localparam int STATUS_W  = 2;
   localparam int LEVEL_O_W = 3;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_BLOCK = 2'd1,
      STATUS_BAD      = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SPLIT,
      ST_DIV,
      ST_CHECK,
      ST_MRG_RD,
      ST_MRG_CHK,
      ST_FIN_RD,
      ST_FIN_CHK,
      ST_RESP
   } state_type;

endpackage

/* src/bba_ifs.sv */
// Valid/ready channel interfaces for allocator requests and responses.
// Field widths come from bba_pkg.
interface bba_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [bba_pkg::SIZE_W-1:0]  request_size;
   logic [bba_pkg::ADDR_W-1:0]  free_address;

   modport source (output valid, command, request_size, free_address, input ready);
   modport sink   (input valid, command, request_size, free_address, output ready);
endinterface

interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::STATUS_W-1:0]  status;
   logic [bba_pkg::ADDR_W-1:0]    block_address;
   logic [bba_pkg::LEVEL_O_W-1:0] largest_free_level;
   logic                          any_free;

   modport source (output valid, status, block_address, largest_free_level, any_free,
                   input ready);
   modport sink   (input valid, status, block_address, largest_free_level, any_free,
                   output ready);
endinterface

/* src/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/buddy_block_allocator.sv */
// Buddy block allocator over one region of MIN_BLOCK << (LEVELS-1) units.
// Requests arrive on req_ch (valid/ready): command 0 allocates request_size units,
// command 1 frees the block of request_size units at free_address. Each request
// gives exactly one response on rsp_ch with a status, the granted or merged block
// address and a summary of the largest free level.
// The free marks of all levels live in a 2^LEVELS x 1 RAM in heap order; per-level
// free counters in flip-flops pick the level and give the summary at once.
// One request is worked on at a time; req_ch.ready is high only while idle.
// Allocate: decode, then a scan of the chosen level from block index 0 up to the
// lowest free block, one mark per cycle through the RAM read port, then one split
// step per level down to the wanted level.
// Free: decode, divide and check, then a read and a check per buddy (up to LEVELS-1
// of them), then a final read and mark update. Bad sizes go from decode to the response.
// After reset the block sweeps every address of the mark RAM, marking only the
// whole region free, and accepts no request during the sweep.
// A finished response waits in the output register while rsp_ch.ready is low; the
// block meanwhile takes the next request and works on it, and holds that request in
// its last state until the register is taken or can be refilled in the same cycle.
module buddy_block_allocator #(
   parameter int LEVELS    = 8,
   parameter int MIN_BLOCK = 8
) (
   input  logic            clock,
   input  logic            reset,
   bba_req_if.sink         req_ch,
   bba_rsp_if.source       rsp_ch
);

   localparam int LW        = (LEVELS > 2) ? $clog2(LEVELS) : 1;
   localparam int UW        = LEVELS - 1;
   localparam int MW        = LEVELS;
   localparam int DEPTH     = 1 << LEVELS;
   localparam int REGION    = MIN_BLOCK << (LEVELS - 1);
   localparam int DIV_SHIFT = 17;
   localparam int RECIP     = ((1 << DIV_SHIFT) + MIN_BLOCK - 1) / MIN_BLOCK;
   localparam int PROD_W    = bba_pkg::ADDR_W + DIV_SHIFT + 1;
   localparam int REM_W     = 16;

   function automatic logic [MW-1:0] lvl_size(input logic [LW-1:0] lvl);
      lvl_size = MW'(1) << (LW'(LEVELS - 1) - lvl);
   endfunction

   function automatic logic [MW-1:0] lvl_base(input logic [LW-1:0] lvl);
      lvl_base = lvl_size(lvl) - MW'(1);
   endfunction

   bba_pkg::state_type             state_ff, state_in;
   logic [MW-1:0]                  clr_ff, clr_in;
   logic [MW-1:0]                  scan_ff, scan_in;
   logic                           pend_ff, pend_in;
   logic [LW-1:0]                  cur_lvl_ff, cur_lvl_in;
   logic [LW-1:0]                  lvl_ff, lvl_in;
   logic [UW-1:0]                  u_ff, u_in;
   logic [bba_pkg::ADDR_W-1:0]     q_ff, q_in;
   logic                           cmd_ff, cmd_in;
   logic [bba_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic [bba_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   bba_pkg::status_type            status_ff, status_in;
   logic [MW-1:0]                  cnt_ff [LEVELS];
   logic [MW-1:0]                  cnt_in [LEVELS];

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bba_pkg::ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [bba_pkg::LEVEL_O_W-1:0]  rsp_largest_ff, rsp_largest_in;
   logic                           rsp_any_ff, rsp_any_in;

   logic                           ram_we;
   logic                           ram_wd;
   logic [MW-1:0]                  ram_waddr;
   logic                           ram_rd;
   logic [LW-1:0]                  addr_lvl_c;
   logic [MW-1:0]                  idx_c;
   logic [MW-1:0]                  mark_addr_c;
   logic                           cnt_inc, cnt_dec;
   logic [LW-1:0]                  cnt_sel;
   logic [LW-1:0]                  size_lvl_c;
   logic                           size_bad_c;
   logic [LW-1:0]                  alloc_lvl_c;
   logic                           alloc_ok_c;
   logic [LW-1:0]                  largest_c;
   logic                           any_c;
   logic [MW-1:0]                  hit_c;
   logic [REM_W-1:0]               qm_c;
   logic                           free_bad_c;
   logic                           rsp_load_c;

   // The one address unit: a level base plus a block index selects a mark.
   assign mark_addr_c = lvl_base(addr_lvl_c) + idx_c;
   assign ram_waddr   = (state_ff == bba_pkg::ST_CLEAR) ? clr_ff : mark_addr_c;
   assign hit_c       = scan_ff - MW'(1);

   bba_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_marks (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wd),
      .rd_addr (mark_addr_c),
      .rd_data (ram_rd)
   );

   // Smallest level holding the size, level to take from, summary, free address check.
   always_comb begin
      size_lvl_c = LW'(LEVELS - 1);
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (32'(size_ff) <= (MIN_BLOCK << l)) begin
            size_lvl_c = LW'(l);
         end
      end
      size_bad_c = (size_ff == '0) || (32'(size_ff) > REGION);

      alloc_lvl_c = '0;
      alloc_ok_c  = 1'b0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (LW'(l) >= size_lvl_c && cnt_ff[l] != '0) begin
            alloc_lvl_c = LW'(l);
            alloc_ok_c  = 1'b1;
         end
      end

      largest_c = '0;
      any_c     = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         if (cnt_ff[l] != '0) begin
            largest_c = LW'(l);
            any_c     = 1'b1;
         end
      end

      qm_c       = REM_W'(q_ff * MIN_BLOCK);
      free_bad_c = (32'(addr_ff) >= REGION) || (REM_W'(addr_ff) != qm_c) ||
                   ((q_ff & ((bba_pkg::ADDR_W'(1) << lvl_ff) - bba_pkg::ADDR_W'(1))) != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LEVELS; l++) begin
            cnt_ff[l] <= (l == LEVELS - 1) ? MW'(1) : '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff        <= scan_in;
      cur_lvl_ff     <= cur_lvl_in;
      lvl_ff         <= lvl_in;
      u_ff           <= u_in;
      q_ff           <= q_in;
      cmd_ff         <= cmd_in;
      size_ff        <= size_in;
      addr_ff        <= addr_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_largest_ff <= rsp_largest_in;
      rsp_any_ff     <= rsp_any_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      cur_lvl_in     = cur_lvl_ff;
      lvl_in         = lvl_ff;
      u_in           = u_ff;
      q_in           = q_ff;
      cmd_in         = cmd_ff;
      size_in        = size_ff;
      addr_in        = addr_ff;
      status_in      = status_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_largest_in = rsp_largest_ff;
      rsp_any_in     = rsp_any_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_load_c     = 1'b0;
      ram_we         = 1'b0;
      ram_wd         = 1'b0;
      addr_lvl_c     = cur_lvl_ff;
      idx_c          = MW'(u_ff >> cur_lvl_ff);
      cnt_inc        = 1'b0;
      cnt_dec        = 1'b0;
      cnt_sel        = cur_lvl_ff;
      req_ch.ready   = 1'b0;

      case (state_ff)
         bba_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wd = (clr_ff == '0);
            clr_in = clr_ff + MW'(1);
            if (clr_ff == MW'(DEPTH - 1)) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               size_in  = req_ch.request_size;
               addr_in  = req_ch.free_address;
               state_in = bba_pkg::ST_DECODE;
            end
         end
         bba_pkg::ST_DECODE: begin
            lvl_in  = size_lvl_c;
            scan_in = '0;
            pend_in = 1'b0;
            if (size_bad_c) begin
               status_in = bba_pkg::STATUS_BAD;
               state_in  = bba_pkg::ST_RESP;
            end else if (cmd_ff == bba_pkg::CMD_ALLOC) begin
               if (alloc_ok_c) begin
                  cur_lvl_in = alloc_lvl_c;
                  state_in   = bba_pkg::ST_SCAN;
               end else begin
                  status_in = bba_pkg::STATUS_NO_BLOCK;
                  state_in  = bba_pkg::ST_RESP;
               end
            end else begin
               state_in = bba_pkg::ST_DIV;
            end
         end
         bba_pkg::ST_SCAN: begin
            // Reads are issued back to back; the data of index scan_ff-1 returns now.
            idx_c   = scan_ff;
            scan_in = scan_ff + MW'(1);
            pend_in = 1'b1;
            if (pend_ff && ram_rd) begin
               idx_c     = hit_c;
               ram_we    = 1'b1;
               ram_wd    = 1'b0;
               cnt_dec   = 1'b1;
               u_in      = UW'(hit_c << cur_lvl_ff);
               status_in = bba_pkg::STATUS_DONE;
               pend_in   = 1'b0;
               state_in  = (cur_lvl_ff > lvl_ff) ? bba_pkg::ST_SPLIT : bba_pkg::ST_RESP;
            end
         end
         bba_pkg::ST_SPLIT: begin
            // Free the upper half at the level below.
            addr_lvl_c = cur_lvl_ff - LW'(1);
            idx_c      = MW'(u_ff >> addr_lvl_c) | MW'(1);
            ram_we     = 1'b1;
            ram_wd     = 1'b1;
            cnt_inc    = 1'b1;
            cnt_sel    = addr_lvl_c;
            cur_lvl_in = addr_lvl_c;
            if (addr_lvl_c == lvl_ff) begin
               state_in = bba_pkg::ST_RESP;
            end
         end
         bba_pkg::ST_DIV: begin
            q_in     = bba_pkg::ADDR_W'((PROD_W'(addr_ff) * PROD_W'(RECIP)) >> DIV_SHIFT);
            state_in = bba_pkg::ST_CHECK;
         end
         bba_pkg::ST_CHECK: begin
            if (free_bad_c) begin
               status_in = bba_pkg::STATUS_BAD;
               state_in  = bba_pkg::ST_RESP;
            end else begin
               u_in       = UW'(q_ff);
               cur_lvl_in = lvl_ff;
               state_in   = (lvl_ff == LW'(LEVELS - 1)) ? bba_pkg::ST_FIN_RD
                                                        : bba_pkg::ST_MRG_RD;
            end
         end
         bba_pkg::ST_MRG_RD: begin
            idx_c    = MW'(u_ff >> cur_lvl_ff) ^ MW'(1);
            state_in = bba_pkg::ST_MRG_CHK;
         end
         bba_pkg::ST_MRG_CHK: begin
            idx_c = MW'(u_ff >> cur_lvl_ff) ^ MW'(1);
            if (ram_rd) begin
               ram_we     = 1'b1;
               ram_wd     = 1'b0;
               cnt_dec    = 1'b1;
               u_in       = u_ff & ~(UW'(1) << cur_lvl_ff);
               cur_lvl_in = cur_lvl_ff + LW'(1);
               state_in   = (cur_lvl_ff + LW'(1) == LW'(LEVELS - 1)) ? bba_pkg::ST_FIN_RD
                                                                     : bba_pkg::ST_MRG_RD;
            end else begin
               state_in = bba_pkg::ST_FIN_RD;
            end
         end
         bba_pkg::ST_FIN_RD: begin
            state_in = bba_pkg::ST_FIN_CHK;
         end
         bba_pkg::ST_FIN_CHK: begin
            // A block freed twice is already marked and must not be counted again.
            ram_we    = 1'b1;
            ram_wd    = 1'b1;
            cnt_inc   = !ram_rd;
            status_in = bba_pkg::STATUS_DONE;
            state_in  = bba_pkg::ST_RESP;
         end
         bba_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load_c     = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_addr_in    = (status_ff == bba_pkg::STATUS_DONE)
                                ? bba_pkg::ADDR_W'(u_ff * MIN_BLOCK) : '0;
               rsp_largest_in = bba_pkg::LEVEL_O_W'(largest_c);
               rsp_any_in     = any_c;
               state_in       = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cnt_inc) begin
         cnt_in[cnt_sel] = cnt_ff[cnt_sel] + MW'(1);
      end else if (cnt_dec) begin
         cnt_in[cnt_sel] = cnt_ff[cnt_sel] - MW'(1);
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.status             = rsp_status_ff;
   assign rsp_ch.block_address      = rsp_addr_ff;
   assign rsp_ch.largest_free_level = rsp_largest_ff;
   assign rsp_ch.any_free           = rsp_any_ff;

   // The counters promise a free mark at the scanned level, so the scan never
   // runs past the end of that level.
   a_scan_in_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::ST_SCAN |-> scan_ff <= lvl_size(cur_lvl_ff))
      else $error("scan ran past the end of its level");

   // Levels below the split block, down to the wanted level, must have been empty.
   a_split_level_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::ST_SPLIT |-> cnt_ff[cur_lvl_ff - LW'(1)] == '0)
      else $error("split freed a half at a level that already held a free block");

   a_merge_below_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bba_pkg::ST_MRG_RD || state_ff == bba_pkg::ST_MRG_CHK)
      |-> cur_lvl_ff < LW'(LEVELS - 1))
      else $error("merge looked for a buddy of the whole region");

   a_top_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[LEVELS - 1] <= MW'(1))
      else $error("more than one free block counted at the top level");

   a_resp_handoff: assert property (@(posedge clock) disable iff (reset)
      state_ff == bba_pkg::ST_RESP && rsp_load_c
      |=> state_ff == bba_pkg::ST_IDLE && rsp_valid_ff)
      else $error("finished request was not presented as a response");

endmodule

/* tb/buddy_alloc_checker.sv */
// Response checker for the buddy block allocator testbench.
// Watches both channels, predicts each response from its own copy of the free marks
// and compares it field by field. Depends on bba_pkg and the channel interfaces.
`timescale 1ns / 100ps

module buddy_alloc_checker (
   input  logic  clock,
   input  logic  reset,
   bba_req_if    req_mon,
   bba_rsp_if    rsp_mon,
   output int    fail_count,
   output int    outstanding
);

   localparam int LEVELS     = 8;
   localparam int MIN_BLOCK  = 8;
   localparam int MARK_COUNT = (1 << LEVELS) - 1;
   localparam int REGION     = MIN_BLOCK << (LEVELS - 1);

   typedef struct packed {
      bba_pkg::status_type             status;
      logic [bba_pkg::ADDR_W-1:0]      block_address;
      logic [bba_pkg::LEVEL_O_W-1:0]   largest_free_level;
      logic                            any_free;
   } alloc_result_type;

   // One free bit per block of every level, stored in heap order (top block first).
   bit               free_mark [MARK_COUNT];
   int unsigned      held_level;
   alloc_result_type predicted_rsp [$];
   alloc_result_type want;

   initial fail_count = 0;

   function automatic int unsigned heap_slot(input int unsigned lvl, input int unsigned idx);
      int unsigned p;
      p = ((1 << (LEVELS - 1 - lvl)) - 1) + idx;
      return (p < MARK_COUNT) ? p : 0;
   endfunction

   function automatic bit find_lowest(input int unsigned lvl, output int unsigned idx);
      idx = 0;
      for (int unsigned i = 0; i < (1 << (LEVELS - 1 - lvl)); i++) begin
         if (free_mark[heap_slot(lvl, i)]) begin
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit fit_level(input int unsigned size, output int unsigned lvl);
      lvl = 0;
      if (size == 0 || size > REGION)
         return 1'b0;
      while (lvl < LEVELS - 1 && (MIN_BLOCK << lvl) < size)
         lvl++;
      return 1'b1;
   endfunction

   function automatic bit update_largest();
      int unsigned idx;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (find_lowest(l, idx)) begin
            held_level = l;
            return 1'b1;
         end
      end
      held_level = 0;
      return 1'b0;
   endfunction

   function automatic alloc_result_type predict_response(input bba_pkg::cmd_type cmd,
                                                         input int unsigned size,
                                                         input int unsigned addr);
      alloc_result_type r;
      int unsigned      lvl;
      int unsigned      j;
      int unsigned      idx;
      int unsigned      bs;
      int unsigned      granted;
      bit               found;
      bit               any;
      r.status = bba_pkg::STATUS_DONE;
      granted  = 0;
      if (!fit_level(size, lvl)) begin
         r.status = bba_pkg::STATUS_BAD;
      end else if (cmd == bba_pkg::CMD_ALLOC) begin
         found = 1'b0;
         j     = lvl;
         while (j < LEVELS && !found) begin
            found = find_lowest(j, idx);
            if (!found)
               j++;
         end
         if (!found) begin
            r.status = bba_pkg::STATUS_NO_BLOCK;
         end else begin
            free_mark[heap_slot(j, idx)] = 1'b0;
            granted = idx * (MIN_BLOCK << j);
            // Split down to the wanted level; every upper half becomes free.
            while (j > lvl) begin
               j--;
               idx = granted / (MIN_BLOCK << j);
               free_mark[heap_slot(j, idx + 1)] = 1'b1;
            end
         end
      end else begin
         bs = MIN_BLOCK << lvl;
         if (addr >= REGION || addr % bs != 0) begin
            r.status = bba_pkg::STATUS_BAD;
         end else begin
            while (lvl < LEVELS - 1) begin
               idx = addr / bs;
               if (!free_mark[heap_slot(lvl, idx ^ 1)])
                  break;
               free_mark[heap_slot(lvl, idx ^ 1)] = 1'b0;
               addr = (idx & ~1) * bs;
               lvl++;
               bs = bs << 1;
            end
            free_mark[heap_slot(lvl, addr / bs)] = 1'b1;
            granted = addr;
         end
      end
      any = update_largest();
      r.block_address      = granted[bba_pkg::ADDR_W-1:0];
      r.largest_free_level = held_level[bba_pkg::LEVEL_O_W-1:0];
      r.any_free           = any;
      return r;
   endfunction

   task automatic compare_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MARK_COUNT; i++)
            free_mark[i] = 1'b0;
         free_mark[heap_slot(LEVELS - 1, 0)] = 1'b1;
         held_level = LEVELS - 1;
         predicted_rsp.delete();
      end else begin
         // Responses are checked before the request of the same edge is predicted.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("response with no request waiting");
               fail_count++;
            end else begin
               want = predicted_rsp.pop_front();
               compare_field("status", want.status, rsp_mon.status);
               compare_field("block_address", want.block_address, rsp_mon.block_address);
               compare_field("largest_free_level", want.largest_free_level,
                             rsp_mon.largest_free_level);
               compare_field("any_free", want.any_free, rsp_mon.any_free);
            end
         end
         if (req_mon.valid && req_mon.ready)
            predicted_rsp.push_back(predict_response(bba_pkg::cmd_type'(req_mon.command),
                                                     req_mon.request_size,
                                                     req_mon.free_address));
      end
      outstanding <= predicted_rsp.size();
   end

endmodule

/* tb/buddy_block_allocator_tb.sv */
// Top of the buddy block allocator testbench: clock, reset, request stimulus,
// response back-pressure and the final verdict. Uses bba_pkg, the channel
// interfaces, the allocator itself and buddy_alloc_checker.
`timescale 1ns / 100ps

module buddy_block_allocator_tb;

   localparam int MIN_UNITS   = 8;
   localparam int RANDOM_REQS = 650;

   typedef struct {
      bba_pkg::cmd_type cmd;
      int unsigned      size;
      int unsigned      addr;
   } block_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;
   int   fail_count;
   int   outstanding;

   block_rec_type in_flight [$];
   block_rec_type live_blocks [$];
   block_rec_type done_req;

   bba_req_if req_bus ();
   bba_rsp_if rsp_bus ();

   buddy_block_allocator #(
      .LEVELS    (8),
      .MIN_BLOCK (MIN_UNITS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   buddy_alloc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.command      = bba_pkg::CMD_ALLOC;
      req_bus.request_size = '0;
      req_bus.free_address = '0;
      rsp_bus.ready        = 1'b0;
   end

   always @(posedge clock) begin
      rsp_bus.ready <= !reset && (calm || $urandom_range(99) >= 28);
   end

   // Track granted blocks so that most frees return a block that is really held.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready && in_flight.size() > 0) begin
            done_req = in_flight.pop_front();
            if (done_req.cmd == bba_pkg::CMD_ALLOC && rsp_bus.status == bba_pkg::STATUS_DONE)
               live_blocks.push_back(block_rec_type'{bba_pkg::CMD_FREE, done_req.size,
                                                     rsp_bus.block_address});
         end
         if (req_bus.valid && req_bus.ready)
            in_flight.push_back(block_rec_type'{bba_pkg::cmd_type'(req_bus.command),
                                                req_bus.request_size,
                                                req_bus.free_address});
      end
   end

   task automatic send_request(input bba_pkg::cmd_type c, input int unsigned s,
                               input int unsigned a);
      if (!calm && $urandom_range(99) < 28) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= c;
      req_bus.request_size <= s[bba_pkg::SIZE_W-1:0];
      req_bus.free_address <= a[bba_pkg::ADDR_W-1:0];
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic random_request();
      int unsigned   pick;
      int unsigned   i;
      block_rec_type blk;
      pick = $urandom_range(99);
      if (pick < 65) begin
         if (live_blocks.size() > 0 &&
             $urandom_range(99) < (live_blocks.size() > 6 ? 70 : 40)) begin
            i   = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[i];
            live_blocks.delete(i);
            send_request(bba_pkg::CMD_FREE, blk.size, blk.addr);
         end else if ($urandom_range(9) < 8) begin
            send_request(bba_pkg::CMD_ALLOC, $urandom_range(1, 64), $urandom);
         end else begin
            send_request(bba_pkg::CMD_ALLOC, $urandom_range(65, 1024), $urandom);
         end
      end else if (pick < 85) begin
         send_request(bba_pkg::cmd_type'($urandom_range(1)), $urandom_range(0, 2047),
                      $urandom);
      end else begin
         // Aligned or misaligned frees of blocks that may not be held.
         send_request(bba_pkg::CMD_FREE, MIN_UNITS << $urandom_range(0, 7),
                      $urandom_range(0, 1023) & ~($urandom_range(1) ? MIN_UNITS - 1 : 0));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_request(bba_pkg::CMD_ALLOC, 0, 0);
      send_request(bba_pkg::CMD_ALLOC, 1025, 0);
      send_request(bba_pkg::CMD_ALLOC, 2047, 1023);
      send_request(bba_pkg::CMD_FREE, 0, 0);
      send_request(bba_pkg::CMD_FREE, 2047, 1023);
      send_request(bba_pkg::CMD_ALLOC, 1, 0);
      send_request(bba_pkg::CMD_ALLOC, 8, 1023);
      send_request(bba_pkg::CMD_ALLOC, 9, 0);
      send_request(bba_pkg::CMD_ALLOC, 1024, 0);
      send_request(bba_pkg::CMD_FREE, 8, 4);
      send_request(bba_pkg::CMD_FREE, 16, 8);
      send_request(bba_pkg::CMD_FREE, 3, 0);
      send_request(bba_pkg::CMD_FREE, 8, 8);
      send_request(bba_pkg::CMD_FREE, 16, 16);
      send_request(bba_pkg::CMD_ALLOC, 1024, 0);
      send_request(bba_pkg::CMD_ALLOC, 8, 0);
      // A free of a block that is not held just sets its mark.
      send_request(bba_pkg::CMD_FREE, 8, 1016);
      send_request(bba_pkg::CMD_ALLOC, 1, 0);
      send_request(bba_pkg::CMD_FREE, 1024, 0);
      send_request(bba_pkg::CMD_ALLOC, 512, 0);
      send_request(bba_pkg::CMD_ALLOC, 512, 0);
      send_request(bba_pkg::CMD_FREE, 512, 512);
      send_request(bba_pkg::CMD_FREE, 512, 0);
      send_request(bba_pkg::CMD_ALLOC, 1023, 0);
      send_request(bba_pkg::CMD_FREE, 1024, 0);
      drain_responses();
      live_blocks.delete();

      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n == 200)
            calm <= 1'b1;
         if (n == 350)
            calm <= 1'b0;
         if (n == 100 || n == 450)
            drain_responses();
         random_request();
      end

      drain_responses();
      repeat (60) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
